FILE: rtl/sorted_insert_table_defines.svh
// Assertion macros for the sorted insert table checker.
// Used by sit_checker.sv only; expects signals named clock and reset in scope.
`ifndef SORTED_INSERT_TABLE_DEFINES_SVH
`define SORTED_INSERT_TABLE_DEFINES_SVH

// Same-cycle implication, ignored while reset is high.
`define SIT_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("sorted_insert_table: same-cycle check failed");

// Next-cycle implication, ignored while reset is high.
`define SIT_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("sorted_insert_table: next-cycle check failed");

// Next-cycle implication that is also checked across reset.
`define SIT_ASSERT_NXT_RST(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("sorted_insert_table: reset check failed");

`endif

FILE: rtl/sit_pkg.sv
// Shared types and constants for the sorted insert table.
// No dependencies; imported by every module of the block.
package sit_pkg;

   localparam int DATA_W = 32;
   localparam int POS_W  = 6;
   localparam int FILL_W = 7;

   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_DUMP   = 1'b1
   } op_type;

   typedef struct packed {
      op_type                   op;
      logic signed [DATA_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] entry_value;
      logic [POS_W-1:0]         position;
      logic [FILL_W-1:0]        fill_count;
      logic                     dropped;
      logic                     last_of_run;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic load_ins;
      logic load_dump;
      logic ins_rd;
      logic ins_shift;
      logic ins_place;
      logic dump_rd;
      logic dump_emit;
      logic drop_rsp;
      logic empty_rsp;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic full;
      logic empty;
      logic slot_zero;
      logic entry_gt;
      logic dump_last;
   } status_type;

endpackage

FILE: rtl/sorted_insert_table.sv
// Sorted insert table: keeps up to CAPACITY signed 32-bit values in ascending order.
// A transaction is taken when start is high and busy is low. Insert (op 0) places the
// value after every entry less than or equal to it, so equal values keep arrival
// order; one result gives the value, its position and the new fill count. Insert on
// a full table drops the value with dropped set. Dump (op 1) emits every entry in
// order, last_of_run on the final one; an empty table gives a single all-zero result
// with last_of_run set. Results appear on rsp_item for exactly one cycle, marked by
// rsp_strobe, and cannot be held off: the receiver must take them as they come.
// Storage: entries live in a memory with one access per cycle and registered read, so
// an insert walks down from the top, reading and then shifting each entry it moves,
// and a dump reads and then emits each entry in turn; busy stays high until the walk
// or dump is through, so no new transaction is taken meanwhile. A dropped insert or
// an empty dump never raises busy. Each result is registered, appearing in the cycle
// after the step that forms it. The table starts empty after reset with no clearing
// pass; depends on sit_pkg, sit_ctrl and sit_dpath.
module sorted_insert_table #(
   parameter int CAPACITY = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  sit_pkg::req_type req_item,
   output logic             rsp_strobe,
   output sit_pkg::rsp_type rsp_item
);
   import sit_pkg::*;

   cmd_type    cmd;
   status_type status;

   // sequencer: decides each step of the insert walk or dump
   sit_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .req_op (req_item.op),
      .status (status),
      .cmd    (cmd),
      .busy   (busy)
   );

   // storage, compare and result register
   sit_dpath #(
      .CAPACITY (CAPACITY)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_item   (req_item),
      .cmd        (cmd),
      .status     (status),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

endmodule

FILE: rtl/sit_dpath.sv
// Datapath of the sorted insert table: entry memory, fill count, pointer, result register.
// Depends on sit_pkg; driven by sit_ctrl commands.
module sit_dpath #(
   parameter int CAPACITY = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  sit_pkg::req_type    req_item,
   input  sit_pkg::cmd_type    cmd,
   output sit_pkg::status_type status,
   output logic                rsp_strobe,
   output sit_pkg::rsp_type    rsp_item
);
   import sit_pkg::*;

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
   localparam logic [CNT_W-1:0] ONE_CNT = CNT_W'(1);

   logic [DATA_W-1:0] mem [CAPACITY];

   logic [CNT_W-1:0]         count_ff, count_in;
   logic [CNT_W-1:0]         ptr_ff, ptr_in;
   logic signed [DATA_W-1:0] value_ff, value_in;
   logic [DATA_W-1:0]        rd_data_ff;
   rsp_type                  rsp_ff, rsp_in;
   logic                     strobe_ff, strobe_in;

   logic                     wr_en, rd_en;
   logic [CNT_W-1:0]         rd_ptr;
   logic [DATA_W-1:0]        wr_data;

   assign wr_en   = cmd.ins_shift || cmd.ins_place;
   assign wr_data = cmd.ins_shift ? rd_data_ff : value_ff;
   assign rd_en   = cmd.ins_rd || cmd.dump_rd;
   assign rd_ptr  = cmd.ins_rd ? (ptr_ff - ONE_CNT) : ptr_ff;

   // single-port style store, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[ptr_ff[IDX_W-1:0]] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_ptr[IDX_W-1:0]];
      end
   end

   always_comb begin
      count_in  = count_ff;
      ptr_in    = ptr_ff;
      value_in  = value_ff;
      rsp_in    = rsp_ff;
      strobe_in = 1'b0;
      priority if (cmd.load_ins) begin
         value_in = req_item.value;
         ptr_in   = count_ff;
      end else if (cmd.load_dump) begin
         ptr_in = '0;
      end else if (cmd.ins_shift) begin
         ptr_in = ptr_ff - ONE_CNT;
      end else if (cmd.ins_place) begin
         count_in           = count_ff + ONE_CNT;
         strobe_in          = 1'b1;
         rsp_in.entry_value = value_ff;
         rsp_in.position    = POS_W'(ptr_ff[IDX_W-1:0]);
         rsp_in.fill_count  = FILL_W'(count_ff + ONE_CNT);
         rsp_in.dropped     = 1'b0;
         rsp_in.last_of_run = 1'b1;
      end else if (cmd.dump_emit) begin
         ptr_in             = ptr_ff + ONE_CNT;
         strobe_in          = 1'b1;
         rsp_in.entry_value = rd_data_ff;
         rsp_in.position    = POS_W'(ptr_ff[IDX_W-1:0]);
         rsp_in.fill_count  = FILL_W'(count_ff);
         rsp_in.dropped     = 1'b0;
         rsp_in.last_of_run = status.dump_last;
      end else if (cmd.drop_rsp) begin
         strobe_in          = 1'b1;
         rsp_in.entry_value = req_item.value;
         rsp_in.position    = '0;
         rsp_in.fill_count  = FILL_W'(count_ff);
         rsp_in.dropped     = 1'b1;
         rsp_in.last_of_run = 1'b1;
      end else if (cmd.empty_rsp) begin
         strobe_in          = 1'b1;
         rsp_in.entry_value = '0;
         rsp_in.position    = '0;
         rsp_in.fill_count  = '0;
         rsp_in.dropped     = 1'b0;
         rsp_in.last_of_run = 1'b1;
      end else begin
         strobe_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         strobe_ff <= strobe_in;
      end
      ptr_ff   <= ptr_in;
      value_ff <= value_in;
      rsp_ff   <= rsp_in;
   end

   assign status.full      = (count_ff == CAP_CNT);
   assign status.empty     = (count_ff == '0);
   assign status.slot_zero = (ptr_ff == '0);
   assign status.entry_gt  = ($signed(rd_data_ff) > value_ff);
   assign status.dump_last = ((ptr_ff + ONE_CNT) == count_ff);

   assign rsp_strobe = strobe_ff;
   assign rsp_item   = rsp_ff;

endmodule

FILE: rtl/sit_ctrl.sv
// Controller of the sorted insert table: sequences insert walks and dumps.
// Depends on sit_pkg; drives sit_dpath through cmd_type.
module sit_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  sit_pkg::op_type     req_op,
   input  sit_pkg::status_type status,
   output sit_pkg::cmd_type    cmd,
   output logic                busy
);
   import sit_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE     = 5'b00001,
      S_INS_RD   = 5'b00010,
      S_INS_CMP  = 5'b00100,
      S_DUMP_RD  = 5'b01000,
      S_DUMP_OUT = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               if (req_op == OP_INSERT) begin
                  if (status.full) begin
                     cmd.drop_rsp = 1'b1;
                  end else begin
                     cmd.load_ins = 1'b1;
                     state_in     = S_INS_RD;
                  end
               end else begin
                  if (status.empty) begin
                     cmd.empty_rsp = 1'b1;
                  end else begin
                     cmd.load_dump = 1'b1;
                     state_in      = S_DUMP_RD;
                  end
               end
            end
         end
         S_INS_RD: begin
            if (status.slot_zero) begin
               cmd.ins_place = 1'b1;
               state_in      = S_IDLE;
            end else begin
               cmd.ins_rd = 1'b1;
               state_in   = S_INS_CMP;
            end
         end
         S_INS_CMP: begin
            if (status.entry_gt) begin
               cmd.ins_shift = 1'b1;
               state_in      = S_INS_RD;
            end else begin
               cmd.ins_place = 1'b1;
               state_in      = S_IDLE;
            end
         end
         S_DUMP_RD: begin
            cmd.dump_rd = 1'b1;
            state_in    = S_DUMP_OUT;
         end
         S_DUMP_OUT: begin
            cmd.dump_emit = 1'b1;
            state_in      = status.dump_last ? S_IDLE : S_DUMP_RD;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule

FILE: rtl/sit_checker.sv
// Port-level checks for sorted_insert_table, bound to the top level.
// Depends on sit_pkg and sorted_insert_table_defines.svh.
`include "sorted_insert_table_defines.svh"

module sit_checker #(
   parameter int CAPACITY = 64
) (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input logic             rsp_strobe,
   input sit_pkg::rsp_type rsp_item
);
   import sit_pkg::*;

   localparam logic [FILL_W-1:0] CAP_FILL = FILL_W'(CAPACITY);

   // no result straight out of reset
   `SIT_ASSERT_NXT_RST(a_reset_quiet, reset, !rsp_strobe)
   // an accepted transaction either keeps the block busy or answers at once
   `SIT_ASSERT_NXT(a_accept_progress, start && !busy, busy || rsp_strobe)
   // a drop only on a full table, as a single result at position zero
   `SIT_ASSERT_IMP(a_drop_full, rsp_strobe && rsp_item.dropped, (rsp_item.fill_count == CAP_FILL) && rsp_item.last_of_run && (rsp_item.position == '0))
   // a placed or dumped entry always lies below the fill count
   `SIT_ASSERT_IMP(a_pos_in_range, rsp_strobe && !rsp_item.dropped && (rsp_item.fill_count != '0), {1'b0, rsp_item.position} < rsp_item.fill_count)

endmodule

bind sorted_insert_table sit_checker #(.CAPACITY(CAPACITY)) u_sit_checker (.*);
